@@ sv/ist_pkg.sv @@
// ----------------------------------------------------------------------------
// ist_pkg
// shared constants, command codes and types for the interpolation search table
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int TableDepth = 1024;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = IdxW + 1;
  localparam int KeyW       = 20;
  localparam int PayW       = 7;
  localparam int CmdW       = 2;
  localparam int OutIdxW    = 10;
  localparam int ProbeW     = 11;
  // numerator of the interpolation: key difference times index span
  localparam int NumW       = KeyW + IdxW;
  localparam int QuoW       = NumW;

  localparam logic [CmdW-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CmdW-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic          start;
    logic [NumW-1:0] num;
    logic [KeyW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QuoW-1:0] quo;
  } div_rsp_t;

endpackage

@@ sv/ist_table_ram.sv @@
// ----------------------------------------------------------------------------
// ist_table_ram
// record memory: key and payload per entry, one write and one read port
// ----------------------------------------------------------------------------
module ist_table_ram (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [ist_pkg::IdxW-1:0]              wr_addr,
  input  logic [ist_pkg::KeyW+ist_pkg::PayW-1:0] wr_data,
  input  logic [ist_pkg::IdxW-1:0]              rd_addr,
  output logic [ist_pkg::KeyW+ist_pkg::PayW-1:0] rd_data
);

  logic [ist_pkg::KeyW+ist_pkg::PayW-1:0] mem [ist_pkg::TableDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/ist_divider.sv @@
// ----------------------------------------------------------------------------
// ist_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ist_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  ist_pkg::div_req_t req,
  output ist_pkg::div_rsp_t rsp
);

  localparam int StepW = $clog2(ist_pkg::NumW + 1);

  logic                      busy_r, busy_nxt;
  logic [StepW-1:0]          step_r, step_nxt;
  logic [ist_pkg::NumW-1:0]  quo_r, quo_nxt;
  logic [ist_pkg::KeyW:0]    rem_r, rem_nxt;
  logic [ist_pkg::KeyW-1:0]  den_r, den_nxt;
  logic                      done_r, done_nxt;
  logic [ist_pkg::KeyW:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    trial    = {rem_r[ist_pkg::KeyW-1:0], quo_r[ist_pkg::NumW-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = StepW'(ist_pkg::NumW);
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[ist_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[ist_pkg::NumW-2:0], 1'b0};
      end
      step_nxt = step_r - StepW'(1);
      if (step_r == StepW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

@@ sv/interpolation_search_table_core.sv @@
// ----------------------------------------------------------------------------
// interpolation_search_table_core
// record table with interpolation search over the loaded entries
// ----------------------------------------------------------------------------
// load, clear and unknown commands give no result
// a search reads the end keys of each range, then reads and compares each probe,
// first running the 30-bit serial division when the probe position needs it;
// at most 1024 probes; the result is registered after the last step
// a waiting result stalls only the next search at its last step
// reset (synchronous, rst_n low) empties the table; memory contents are not cleared
module interpolation_search_table_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ist_pkg::CmdW-1:0]    in_cmd,
  input  logic [ist_pkg::KeyW-1:0]    in_rec_key,
  input  logic [ist_pkg::PayW-1:0]    in_rec_payload,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [ist_pkg::OutIdxW-1:0] out_hit_index,
  output logic [ist_pkg::PayW-1:0]    out_hit_payload,
  output logic [ist_pkg::ProbeW-1:0]  out_probe_count
);

  localparam int IW = ist_pkg::IdxW;
  localparam int KW = ist_pkg::KeyW;
  localparam int PW = ist_pkg::PayW;
  localparam int CW = ist_pkg::CntW;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RDLO  = 9'b000000010,
    S_RDHI  = 9'b000000100,
    S_CHECK = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_RDPOS = 9'b000100000,
    S_CMP   = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_WAITLO = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [IW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt, pos_r, pos_nxt;
  logic [KW-1:0]       klo_r, klo_nxt, khi_r, khi_nxt;
  logic [ist_pkg::ProbeW-1:0] probes_r, probes_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic                found_r, found_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [PW-1:0]       pay_r, pay_nxt;
  logic                ofound_r, ofound_nxt;
  logic [IW-1:0]       oidx_r, oidx_nxt;
  logic [PW-1:0]       opay_r, opay_nxt;
  logic [ist_pkg::ProbeW-1:0] oprobes_r, oprobes_nxt;

  logic                wr_en;
  logic [IW-1:0]       rd_addr;
  logic [KW+PW-1:0]    rd_data;
  logic [KW-1:0]       rd_key;
  logic [PW-1:0]       rd_pay;
  ist_pkg::div_req_t   dreq;
  ist_pkg::div_rsp_t   drsp;
  logic [ist_pkg::QuoW:0]   psum;

  logic accept;
  assign accept  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign wr_en   = accept && (in_cmd == ist_pkg::CMD_LOAD)
                   && (count_r < CW'(ist_pkg::TableDepth));
  assign rd_key  = rd_data[KW+PW-1:PW];
  assign rd_pay  = rd_data[PW-1:0];

  ist_table_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IW-1:0]),
    .wr_data ({in_rec_key, in_rec_payload}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ist_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  assign dreq.num = ist_pkg::NumW'(key_r - klo_r) * ist_pkg::NumW'(hi_r - lo_r);
  assign dreq.den = khi_r - klo_r;
  assign psum     = {1'b0, drsp.quo} + (ist_pkg::QuoW+1)'(lo_r);

  always_comb begin
    rd_addr = pos_r;
    case (state_r)
      S_RDLO:  rd_addr = lo_r;
      S_RDHI:  rd_addr = hi_r;
      default: rd_addr = pos_r;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    key_nxt     = key_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    pos_nxt     = pos_r;
    klo_nxt     = klo_r;
    khi_nxt     = khi_r;
    probes_nxt  = probes_r;
    ovalid_nxt  = ovalid_r && out_stall;
    found_nxt   = found_r;
    idx_nxt     = idx_r;
    pay_nxt     = pay_r;
    ofound_nxt  = ofound_r;
    oidx_nxt    = oidx_r;
    opay_nxt    = opay_r;
    oprobes_nxt = oprobes_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            ist_pkg::CMD_LOAD: begin
              if (wr_en) count_nxt = count_r + CW'(1);
            end
            ist_pkg::CMD_CLEAR: count_nxt = '0;
            ist_pkg::CMD_SEARCH: begin
              key_nxt    = in_rec_key;
              probes_nxt = '0;
              found_nxt  = 1'b0;
              idx_nxt    = '0;
              pay_nxt    = '0;
              lo_nxt     = '0;
              hi_nxt     = IW'(count_r - CW'(1));
              state_nxt  = (count_r == '0) ? S_OUT : S_RDLO;
            end
            default: ;
          endcase
        end
      end
      S_RDLO:   state_nxt = S_WAITLO;
      S_WAITLO: begin
        klo_nxt   = rd_key;
        state_nxt = S_RDHI;
      end
      S_RDHI:   state_nxt = S_CHECK;
      S_CHECK: begin
        khi_nxt = rd_key;
        if (key_r < klo_r || key_r > rd_key) begin
          state_nxt = S_OUT;
        end else if (rd_key == klo_r) begin
          pos_nxt   = lo_r;
          state_nxt = S_RDPOS;
        end else begin
          state_nxt = S_DIV;
        end
        // khi_r is needed by the divider request next cycle
      end
      S_DIV: begin
        if (drsp.done) begin
          if (psum > (ist_pkg::QuoW+1)'(hi_r)) pos_nxt = hi_r;
          else pos_nxt = IW'(psum);
          state_nxt = S_RDPOS;
        end
      end
      S_RDPOS: state_nxt = S_CMP;
      S_CMP: begin
        probes_nxt = probes_r + ist_pkg::ProbeW'(1);
        if (rd_key == key_r) begin
          found_nxt = 1'b1;
          idx_nxt   = pos_r;
          pay_nxt   = rd_pay;
          state_nxt = S_OUT;
        end else if (rd_key < key_r) begin
          if (pos_r >= hi_r) state_nxt = S_OUT;
          else begin
            lo_nxt    = pos_r + IW'(1);
            state_nxt = S_RDLO;
          end
        end else begin
          if (pos_r <= lo_r) state_nxt = S_OUT;
          else begin
            hi_nxt    = pos_r - IW'(1);
            state_nxt = S_RDLO;
          end
        end
      end
      S_OUT: begin
        if (!(ovalid_r && out_stall)) begin
          ovalid_nxt  = 1'b1;
          ofound_nxt  = found_r;
          oidx_nxt    = idx_r;
          opay_nxt    = pay_r;
          oprobes_nxt = probes_r;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // divider starts the cycle after the end keys are known
  logic div_go_r;
  always_ff @(posedge clk) begin
    if (!rst_n) div_go_r <= 1'b0;
    else div_go_r <= (state_r == S_CHECK) && (state_nxt == S_DIV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
    key_r     <= key_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    pos_r     <= pos_nxt;
    klo_r     <= klo_nxt;
    khi_r     <= khi_nxt;
    probes_r  <= probes_nxt;
    found_r   <= found_nxt;
    idx_r     <= idx_nxt;
    pay_r     <= pay_nxt;
    ofound_r  <= ofound_nxt;
    oidx_r    <= oidx_nxt;
    opay_r    <= opay_nxt;
    oprobes_r <= oprobes_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_found       = ofound_r;
  assign out_hit_index   = ist_pkg::OutIdxW'(oidx_r);
  assign out_hit_payload = opay_r;
  assign out_probe_count = oprobes_r;

  // divider start comes from the registered go flag
  assign dreq.start = div_go_r;

endmodule

@@ sv/ist_checker.sv @@
// ----------------------------------------------------------------------------
// ist_checker
// port-level checks for the interpolation search table
// ----------------------------------------------------------------------------
module ist_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_found,
  input logic [ist_pkg::OutIdxW-1:0] out_hit_index,
  input logic [ist_pkg::PayW-1:0]    out_hit_payload,
  input logic [ist_pkg::ProbeW-1:0]  out_probe_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_probe_count))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_hit_index == '0 && out_hit_payload == '0)
    else $error("miss with nonzero index or payload");

  a_hit_probed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_probe_count != '0)
    else $error("hit without a probe");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind interpolation_search_table_core ist_checker u_ist_checker (.*);
